/* hw/rtl/integer_matrix_multiply_assert.svh */
// assertion macros for the integer matrix multiply checker
// clocked on clk_i, disabled while rst_ni is low
`ifndef INTEGER_MATRIX_MULTIPLY_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_ASSERT_SVH

// same-cycle implication
`define IMM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/imm_pkg.sv */
// shared types and constants of the integer matrix multiply block
// no dependencies
package imm_pkg;

  localparam int ELEM_W      = 32;
  localparam int DIM_REG_W   = 4;
  localparam int IDX_OUT_W   = 3;
  localparam int CFG_ADDR_W  = 2;
  localparam int NUM_REGS    = 4;
  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = 40;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROWS_A = 2'd0,
    REG_COLS_A = 2'd1,
    REG_ROWS_B = 2'd2,
    REG_COLS_B = 2'd3
  } imm_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } imm_state_e;

endpackage

/* hw/rtl/imm_ram.sv */
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/integer_matrix_multiply.sv */
// integer matrix multiply: top level with load counters, sequencer and shared mac
// depends on imm_pkg and imm_ram
//
// usage:
//   cfg channel (cfg_valid_i/cfg_ready_o, cfg_addr_i, cfg_data_i) writes the
//   dimensions rows_a, cols_a, rows_b, cols_b; any write restarts loading.
//   slave stream takes elements of A row-major, then B row-major, one per item.
//   loading items are taken back to back while the output is free and give no result.
//   after the last B item the master stream gives rows_a*cols_b results in
//   row-major order, tlast on the final one, tuser flags a dimension error.
//   each result reads cols_a element pairs through the shared
//   multiply-accumulate unit, drains through the ram read, product register
//   and accumulate steps, and is then given out in the output state.
//   if cols_a differs from rows_b, each item gives one error result at once.
//   the input side is not ready while products are computed.
//   reset clears the dimensions to 1 and the load position; store contents
//   are left as they are.
//   a stalled receiver holds the output register, the input and the sequencer at its output step.
module integer_matrix_multiply #(
  parameter int MAX_DIM = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [imm_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [imm_pkg::DIM_REG_W-1:0]      cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // elem_value [31:0]
  input  logic [imm_pkg::TDATA_IN_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // product_value [31:0], out_row [34:32], out_col [37:35], zero [39:38]
  output logic [imm_pkg::TDATA_OUT_W-1:0]    m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  // dim_error [0]
  output logic                               m_axis_tuser_o
);

  import imm_pkg::*;

  localparam int IW    = $clog2(MAX_DIM);
  localparam int DEPTH = 2 ** (2 * IW);
  localparam int AW    = 2 * IW;

  function automatic logic [IW-1:0] dim_m1(input logic [DIM_REG_W-1:0] v);
    logic [IW-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > MAX_DIM) begin
      res = IW'(MAX_DIM - 1);
    end else begin
      res = IW'(v - 4'd1);
    end
    return res;
  endfunction

  imm_state_e state_q, state_d;

  logic [DIM_REG_W-1:0] cfg_q [NUM_REGS];
  logic [DIM_REG_W-1:0] cfg_d [NUM_REGS];

  logic [IW-1:0] ra_m1, ca_m1, rb_m1, cb_m1;
  logic          mismatch;

  logic          ld_b_q, ld_b_d;
  logic [IW-1:0] ld_row_q, ld_row_d, ld_col_q, ld_col_d;
  logic [IW-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic          rd_v_q, rd_v_d, mul_v_q, mul_v_d;
  logic [ELEM_W-1:0] prod_q, prod_d, acc_q, acc_d;
  logic [ELEM_W-1:0] mul_lo;

  logic                   m_valid_q, m_valid_d, m_last_q, m_last_d, m_err_q, m_err_d;
  logic [TDATA_OUT_W-1:0] m_data_q, m_data_d;

  logic          in_acc, out_free, load_go, run_start;
  logic          ld_end_col, ld_end, k_end, res_last;
  logic [IW-1:0] ld_lim_col, ld_lim_row;

  logic              a_we, b_we, rd_en;
  logic [AW-1:0]     waddr, a_raddr, b_raddr;
  logic [ELEM_W-1:0] a_rdata, b_rdata;

  assign ra_m1    = dim_m1(cfg_q[REG_ROWS_A]);
  assign ca_m1    = dim_m1(cfg_q[REG_COLS_A]);
  assign rb_m1    = dim_m1(cfg_q[REG_ROWS_B]);
  assign cb_m1    = dim_m1(cfg_q[REG_COLS_B]);
  assign mismatch = (ca_m1 != rb_m1);

  assign cfg_ready_o     = 1'b1;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign ld_lim_col = ld_b_q ? cb_m1 : ca_m1;
  assign ld_lim_row = ld_b_q ? rb_m1 : ra_m1;
  assign ld_end_col = (ld_col_q == ld_lim_col);
  assign ld_end     = ld_end_col && (ld_row_q == ld_lim_row);
  assign load_go    = in_acc && !mismatch;
  assign run_start  = load_go && ld_b_q && ld_end;
  assign k_end      = (k_q == ca_m1);
  assign res_last   = (r_q == ra_m1) && (c_q == cb_m1);

  assign a_we    = load_go && !ld_b_q;
  assign b_we    = load_go && ld_b_q;
  assign waddr   = {ld_row_q, ld_col_q};
  assign rd_en   = (state_q == ST_RUN);
  assign a_raddr = {r_q, k_q};
  assign b_raddr = {k_q, c_q};

  imm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata_i[ELEM_W-1:0]),
    .re_i    (rd_en),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  imm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata_i[ELEM_W-1:0]),
    .re_i    (rd_en),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // low half of the product is the same for signed and unsigned operands
  assign mul_lo = a_rdata * b_rdata;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (run_start) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (k_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !mul_v_q) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = res_last ? ST_IDLE : ST_RUN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (imm_reg_e'(cfg_addr_i))
        REG_ROWS_A: cfg_d[REG_ROWS_A] = cfg_data_i;
        REG_COLS_A: cfg_d[REG_COLS_A] = cfg_data_i;
        REG_ROWS_B: cfg_d[REG_ROWS_B] = cfg_data_i;
        REG_COLS_B: cfg_d[REG_COLS_B] = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    ld_b_d    = ld_b_q;
    ld_row_d  = ld_row_q;
    ld_col_d  = ld_col_q;
    r_d       = r_q;
    c_d       = c_q;
    k_d       = k_q;
    acc_d     = acc_q;
    rd_v_d    = rd_en;
    mul_v_d   = rd_v_q;
    prod_d    = mul_lo;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    m_err_d   = m_err_q;

    if (cfg_valid_i) begin
      ld_b_d   = 1'b0;
      ld_row_d = '0;
      ld_col_d = '0;
    end else if (load_go) begin
      if (ld_end) begin
        ld_b_d   = !ld_b_q;
        ld_row_d = '0;
        ld_col_d = '0;
      end else if (ld_end_col) begin
        ld_col_d = '0;
        ld_row_d = ld_row_q + 1'b1;
      end else begin
        ld_col_d = ld_col_q + 1'b1;
      end
    end

    if (in_acc && mismatch) begin
      m_valid_d = 1'b1;
      m_data_d  = '0;
      m_last_d  = 1'b0;
      m_err_d   = 1'b1;
    end

    if (mul_v_q) begin
      acc_d = acc_q + prod_q;
    end

    case (state_q)
      ST_IDLE: begin
        r_d   = '0;
        c_d   = '0;
        k_d   = '0;
        acc_d = '0;
      end
      ST_RUN: begin
        k_d = k_end ? '0 : k_q + 1'b1;
      end
      ST_DRAIN: begin
        k_d = '0;
      end
      ST_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {2'b00, IDX_OUT_W'(c_q), IDX_OUT_W'(r_q), acc_q};
          m_last_d  = res_last;
          m_err_d   = 1'b0;
          acc_d     = '0;
          if (!res_last) begin
            if (c_q == cb_m1) begin
              c_d = '0;
              r_d = r_q + 1'b1;
            end else begin
              c_d = c_q + 1'b1;
            end
          end
        end
      end
      default: begin
        k_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_q     <= '{default: DIM_RESET};
      ld_b_q    <= 1'b0;
      ld_row_q  <= '0;
      ld_col_q  <= '0;
      r_q       <= '0;
      c_q       <= '0;
      k_q       <= '0;
      rd_v_q    <= 1'b0;
      mul_v_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cfg_q     <= cfg_d;
      ld_b_q    <= ld_b_d;
      ld_row_q  <= ld_row_d;
      ld_col_q  <= ld_col_d;
      r_q       <= r_d;
      c_q       <= c_d;
      k_q       <= k_d;
      rd_v_q    <= rd_v_d;
      mul_v_q   <= mul_v_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
    m_err_q  <= m_err_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_err_q;

endmodule

/* hw/rtl/imm_checker.sv */
// port-level checker for the integer matrix multiply top level, with its bind
// depends on imm_pkg and integer_matrix_multiply_assert.svh
`include "integer_matrix_multiply_assert.svh"

module imm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_tvalid_i,
  input logic                            s_tready_i,
  input logic                            m_tvalid_i,
  input logic                            m_tready_i,
  input logic [imm_pkg::TDATA_OUT_W-1:0] m_tdata_i,
  input logic                            m_tlast_i,
  input logic                            m_tuser_i
);

  import imm_pkg::*;

  `IMM_ASSERT_NEXT(a_out_hold, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i) && $stable(m_tlast_i) && $stable(m_tuser_i), "stalled result changed")

  `IMM_ASSERT(a_err_clean, m_tvalid_i && m_tuser_i, (m_tdata_i == '0) && !m_tlast_i, "error result carries data")

  `IMM_ASSERT(a_no_overrun, s_tvalid_i && s_tready_i && m_tvalid_i, m_tready_i, "item taken while result slot full")

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tlast_i  (m_axis_tlast_o),
  .m_tuser_i  (m_axis_tuser_o)
);
